@@ hw/rtl/rcrsr_pkg.sv @@
package rcrsr_pkg;

   // ring geometry
   localparam int MAX_SLOTS = 256;
   localparam int INDEX_W   = $clog2(MAX_SLOTS);
   localparam int COUNT_W   = INDEX_W + 1;
   localparam int SIZE_W    = 16;
   localparam int ADDR_W    = 32;
   localparam int TOTAL_W   = 32;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SLOT_BYTES = 2'd0,
      CSR_SLOT_COUNT = 2'd1,
      CSR_DATA_BASE  = 2'd2
   } csr_index_type;

   localparam logic [SIZE_W-1:0]  SLOT_BYTES_RESET = SIZE_W'(64);
   localparam logic [COUNT_W-1:0] SLOT_COUNT_RESET = COUNT_W'(MAX_SLOTS);
   localparam logic [ADDR_W-1:0]  DATA_BASE_RESET  = '0;

   // request operations
   typedef enum logic [1:0] {
      FUNC_RESERVE = 2'd0,
      FUNC_COMMIT  = 2'd1,
      FUNC_READ    = 2'd2,
      FUNC_RELEASE = 2'd3
   } func_type;

   // result status codes
   typedef enum logic [2:0] {
      STATUS_OK            = 3'd0,
      STATUS_TOO_LARGE     = 3'd1,
      STATUS_FULL          = 3'd2,
      STATUS_NONE_RESERVED = 3'd3,
      STATUS_EMPTY         = 3'd4
   } status_type;

   // result payload, first field in the lowest bits
   localparam int RSP_FIELDS_W = 3 + ADDR_W + SIZE_W + 4 * TOTAL_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_STATUS_LO  = 0;
   localparam int RSP_ADDR_LO    = 3;
   localparam int RSP_CONTENT_LO = RSP_ADDR_LO + ADDR_W;

   // effective ring length: slot count clamped to [2, MAX_SLOTS]
   function automatic logic [COUNT_W-1:0] ring_len(input logic [COUNT_W-1:0] count);
      logic [COUNT_W-1:0] len;
      len = count;
      if (count < COUNT_W'(2)) begin
         len = COUNT_W'(2);
      end else if (count > COUNT_W'(MAX_SLOTS)) begin
         len = COUNT_W'(MAX_SLOTS);
      end
      return len;
   endfunction

   // step an index by one, wrapping at the ring length
   function automatic logic [INDEX_W-1:0] advance(input logic [INDEX_W-1:0] idx,
                                                  input logic [COUNT_W-1:0] len);
      logic [COUNT_W-1:0] nxt;
      nxt = {1'b0, idx} + COUNT_W'(1);
      if (nxt >= len) begin
         nxt = '0;
      end
      return nxt[INDEX_W-1:0];
   endfunction

endpackage

@@ hw/rtl/rcrsr_ram.sv @@
module rcrsr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port (old data on collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/reserve_commit_release_slot_ring.sv @@
// Slot ring with reserve, commit and release indices. One request is taken per
// clock and its result is loaded into the result register with it; the
// block keeps taking requests while a result is stalled only if that result
// is taken in the same cycle, so sustained rate is one item per cycle when
// results are not stalled. The per-slot committed sizes live in a 256-entry
// RAM whose registered read port always follows the release index, with a
// forwarding register covering a commit to that same slot, so a read sees
// even a size just committed. The size RAM is not cleared: only slots that
// have been committed read back meaningful sizes. Configuration (slot size,
// slot count, data base) must be written only while no request is in flight.
module reserve_commit_release_slot_ring (
   input  logic                                      clock,
   input  logic                                      reset,
   // request channel
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [rcrsr_pkg::SIZE_W-1:0]              req_tdata,  // req_bytes[15:0]
   input  logic [1:0]                                req_tuser,  // func[1:0]
   // result channel
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // status[2:0], slot_address[34:3], content_bytes[50:35],
   // written_bytes_total[82:51], written_slots_total[114:83],
   // read_bytes_total[146:115], read_slots_total[178:147], zero pad above
   output logic [rcrsr_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   // configuration write channel
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [rcrsr_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [rcrsr_pkg::CSR_DATA_W-1:0]          csr_data
);

   localparam int IW = rcrsr_pkg::INDEX_W;
   localparam int CW = rcrsr_pkg::COUNT_W;
   localparam int SW = rcrsr_pkg::SIZE_W;
   localparam int AW = rcrsr_pkg::ADDR_W;
   localparam int TW = rcrsr_pkg::TOTAL_W;

   // configuration registers
   logic [SW-1:0] slot_bytes_ff;
   logic [CW-1:0] slot_count_ff;
   logic [AW-1:0] data_base_ff;

   // ring state
   logic [IW-1:0] reserve_index_ff, reserve_index_in;
   logic [IW-1:0] commit_index_ff, commit_index_in;
   logic [IW-1:0] release_index_ff, release_index_in;
   logic [TW-1:0] write_bytes_ff, write_bytes_in;
   logic [TW-1:0] write_slots_ff, write_slots_in;
   logic [TW-1:0] read_bytes_ff, read_bytes_in;
   logic [TW-1:0] read_slots_ff, read_slots_in;

   // result register
   logic                      rsp_valid_ff;
   rcrsr_pkg::status_type     status_ff, status_in;
   logic [AW-1:0]             address_ff, address_in;
   logic [SW-1:0]             content_ff, content_in;

   // size RAM and forwarding
   logic          size_wr_en;
   logic [SW-1:0] size_rd_data;
   logic          fwd_valid_ff, fwd_valid_in;
   logic [SW-1:0] fwd_data_ff;
   logic [SW-1:0] release_size;

   logic                  accept;
   rcrsr_pkg::func_type   func;
   logic [CW-1:0]         len;
   logic                  too_large;
   logic [IW+SW-1:0]      reserve_offset;
   logic [IW+SW-1:0]      release_offset;

   // nothing is taken while reset is held
   assign csr_ready  = !reset;
   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign func       = rcrsr_pkg::func_type'(req_tuser);
   assign len        = rcrsr_pkg::ring_len(slot_count_ff);
   assign too_large  = req_tdata > slot_bytes_ff;

   assign reserve_offset = {{SW{1'b0}}, reserve_index_ff} * {{IW{1'b0}}, slot_bytes_ff};
   assign release_offset = {{SW{1'b0}}, release_index_ff} * {{IW{1'b0}}, slot_bytes_ff};

   // size of the oldest committed slot, forwarded when just written
   assign release_size = fwd_valid_ff ? fwd_data_ff : size_rd_data;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_bytes_ff <= rcrsr_pkg::SLOT_BYTES_RESET;
         slot_count_ff <= rcrsr_pkg::SLOT_COUNT_RESET;
         data_base_ff  <= rcrsr_pkg::DATA_BASE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rcrsr_pkg::CSR_SLOT_BYTES: slot_bytes_ff <= csr_data[SW-1:0];
            rcrsr_pkg::CSR_SLOT_COUNT: slot_count_ff <= csr_data[CW-1:0];
            rcrsr_pkg::CSR_DATA_BASE:  data_base_ff  <= csr_data[AW-1:0];
            default: ;
         endcase
      end
   end

   // operation decode and next state
   always_comb begin
      reserve_index_in = reserve_index_ff;
      commit_index_in  = commit_index_ff;
      release_index_in = release_index_ff;
      write_bytes_in   = write_bytes_ff;
      write_slots_in   = write_slots_ff;
      read_bytes_in    = read_bytes_ff;
      read_slots_in    = read_slots_ff;
      status_in        = rcrsr_pkg::STATUS_OK;
      address_in       = '0;
      content_in       = '0;
      size_wr_en       = 1'b0;
      case (func)
         rcrsr_pkg::FUNC_RESERVE: begin
            if (too_large) begin
               status_in = rcrsr_pkg::STATUS_TOO_LARGE;
            end else if (rcrsr_pkg::advance(reserve_index_ff, len) == release_index_ff) begin
               status_in = rcrsr_pkg::STATUS_FULL;
            end else begin
               address_in       = data_base_ff + AW'(reserve_offset);
               reserve_index_in = rcrsr_pkg::advance(reserve_index_ff, len);
            end
         end
         rcrsr_pkg::FUNC_COMMIT: begin
            if (too_large) begin
               status_in = rcrsr_pkg::STATUS_TOO_LARGE;
            end else if (commit_index_ff == reserve_index_ff) begin
               status_in = rcrsr_pkg::STATUS_NONE_RESERVED;
            end else begin
               size_wr_en      = accept;
               write_bytes_in  = write_bytes_ff + TW'(req_tdata);
               write_slots_in  = write_slots_ff + TW'(1);
               content_in      = req_tdata;
               commit_index_in = rcrsr_pkg::advance(commit_index_ff, len);
            end
         end
         rcrsr_pkg::FUNC_READ: begin
            if (release_index_ff == commit_index_ff) begin
               status_in = rcrsr_pkg::STATUS_EMPTY;
            end else begin
               read_bytes_in = read_bytes_ff + TW'(release_size);
               read_slots_in = read_slots_ff + TW'(1);
               content_in    = release_size;
               address_in    = data_base_ff + AW'(release_offset);
            end
         end
         rcrsr_pkg::FUNC_RELEASE: begin
            if (release_index_ff == commit_index_ff) begin
               status_in = rcrsr_pkg::STATUS_EMPTY;
            end else begin
               release_index_in = rcrsr_pkg::advance(release_index_ff, len);
            end
         end
         default: ;
      endcase
      if (!accept) begin
         release_index_in = release_index_ff;
      end
   end

   // a commit into the slot the RAM is about to read must be forwarded
   assign fwd_valid_in = size_wr_en && (commit_index_ff == release_index_in);

   // ring state and counters, updated on each request transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         reserve_index_ff <= '0;
         commit_index_ff  <= '0;
         release_index_ff <= '0;
         write_bytes_ff   <= '0;
         write_slots_ff   <= '0;
         read_bytes_ff    <= '0;
         read_slots_ff    <= '0;
         fwd_valid_ff     <= 1'b0;
      end else begin
         fwd_valid_ff <= fwd_valid_in;
         if (accept) begin
            reserve_index_ff <= reserve_index_in;
            commit_index_ff  <= commit_index_in;
            release_index_ff <= release_index_in;
            write_bytes_ff   <= write_bytes_in;
            write_slots_ff   <= write_slots_in;
            read_bytes_ff    <= read_bytes_in;
            read_slots_ff    <= read_slots_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= req_tdata;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff  <= status_in;
         address_ff <= address_in;
         content_ff <= content_in;
      end
   end

   // committed sizes, read port tracks the release index
   rcrsr_ram #(
      .WIDTH (SW),
      .DEPTH (rcrsr_pkg::MAX_SLOTS)
   ) u_size_ram (
      .clock   (clock),
      .wr_en   (size_wr_en),
      .wr_addr (commit_index_ff),
      .wr_data (req_tdata),
      .rd_addr (release_index_in),
      .rd_data (size_rd_data)
   );

   // counters only move on a transfer, which also loads the result register
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rcrsr_pkg::RSP_DATA_W'({read_slots_ff, read_bytes_ff,
                                               write_slots_ff, write_bytes_ff,
                                               content_ff, address_ff, status_ff});

endmodule

@@ hw/rtl/rcrsr_checker.sv @@
module rcrsr_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [rcrsr_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int SL = rcrsr_pkg::RSP_STATUS_LO;
   localparam int AL = rcrsr_pkg::RSP_ADDR_LO;
   localparam int CL = rcrsr_pkg::RSP_CONTENT_LO;

   logic [2:0]                     rsp_status;
   logic [rcrsr_pkg::ADDR_W-1:0]   rsp_address;
   logic [rcrsr_pkg::SIZE_W-1:0]   rsp_content;

   assign rsp_status  = rsp_tdata[SL +: 3];
   assign rsp_address = rsp_tdata[AL +: rcrsr_pkg::ADDR_W];
   assign rsp_content = rsp_tdata[CL +: rcrsr_pkg::SIZE_W];

   // no result left over from before reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // a stalled result blocks new requests
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while result stalled");

   // a request transfer always yields a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("request transfer without result");

   // failures report no address and no size
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status != 3'(rcrsr_pkg::STATUS_OK)
         |-> rsp_address == '0 && rsp_content == '0)
      else $error("failed result carries address or size");

endmodule

bind reserve_commit_release_slot_ring rcrsr_checker u_rcrsr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ dv/reserve_commit_release_slot_ring_tb.sv @@
`timescale 1ns / 100ps

module reserve_commit_release_slot_ring_tb;

   localparam int MAX_SLOTS      = rcrsr_pkg::MAX_SLOTS;
   localparam int INDEX_W        = rcrsr_pkg::INDEX_W;
   localparam int COUNT_W        = rcrsr_pkg::COUNT_W;
   localparam int SIZE_W         = rcrsr_pkg::SIZE_W;
   localparam int ADDR_W         = rcrsr_pkg::ADDR_W;
   localparam int TOTAL_W        = rcrsr_pkg::TOTAL_W;
   localparam int CSR_INDEX_W    = rcrsr_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W     = rcrsr_pkg::CSR_DATA_W;
   localparam int RSP_DATA_W     = rcrsr_pkg::RSP_DATA_W;
   localparam int RSP_STATUS_LO  = rcrsr_pkg::RSP_STATUS_LO;
   localparam int RSP_ADDR_LO    = rcrsr_pkg::RSP_ADDR_LO;
   localparam int RSP_CONTENT_LO = rcrsr_pkg::RSP_CONTENT_LO;

   localparam int WB_LO = RSP_CONTENT_LO + SIZE_W;
   localparam int WS_LO = WB_LO + TOTAL_W;
   localparam int RB_LO = WS_LO + TOTAL_W;
   localparam int RS_LO = RB_LO + TOTAL_W;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      rcrsr_pkg::func_type  func;
      logic [SIZE_W-1:0]    nbytes;
   } ring_req_type;

   typedef struct {
      rcrsr_pkg::status_type  status;
      logic [ADDR_W-1:0]      addr;
      logic [SIZE_W-1:0]      content;
      logic [TOTAL_W-1:0]     wr_bytes;
      logic [TOTAL_W-1:0]     wr_slots;
      logic [TOTAL_W-1:0]     rd_bytes;
      logic [TOTAL_W-1:0]     rd_slots;
   } ring_rsp_type;

   // DUT connections
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [SIZE_W-1:0]         req_tdata = '0;
   logic [1:0]                req_tuser = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]     rsp_tdata;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_data = '0;

   // predicted ring state and configuration
   logic [SIZE_W-1:0]         cfg_slot_bytes = SIZE_W'(64);
   logic [COUNT_W-1:0]        cfg_slot_count = COUNT_W'(MAX_SLOTS);
   logic [ADDR_W-1:0]         cfg_data_base = '0;
   logic [INDEX_W-1:0]        rsv_idx = '0;
   logic [INDEX_W-1:0]        cmt_idx = '0;
   logic [INDEX_W-1:0]        rel_idx = '0;
   logic [SIZE_W-1:0]         size_table [MAX_SLOTS];
   logic [TOTAL_W-1:0]        wr_bytes = '0;
   logic [TOTAL_W-1:0]        wr_slots = '0;
   logic [TOTAL_W-1:0]        rd_bytes = '0;
   logic [TOTAL_W-1:0]        rd_slots = '0;

   ring_req_type              req_backlog [$];
   ring_rsp_type              rsp_expected [$];

   int                        req_hold = 0;
   int                        rsp_hold = 0;
   bit                        req_calm = 1'b0;
   bit                        rsp_calm = 1'b0;
   int                        fail_count = 0;
   int                        shown = 0;
   int                        cycles = 0;

   reserve_commit_release_slot_ring u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ring step with wrap at the clamped slot count
   function automatic logic [INDEX_W-1:0] next_index(input logic [INDEX_W-1:0] idx);
      logic [COUNT_W-1:0] len;
      logic [COUNT_W-1:0] nxt;
      len = cfg_slot_count;
      if (len < COUNT_W'(2)) begin
         len = COUNT_W'(2);
      end else if (len > COUNT_W'(MAX_SLOTS)) begin
         len = COUNT_W'(MAX_SLOTS);
      end
      nxt = {1'b0, idx} + COUNT_W'(1);
      return (nxt >= len) ? '0 : nxt[INDEX_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] slot_addr(input logic [INDEX_W-1:0] idx);
      return cfg_data_base + ADDR_W'(idx) * ADDR_W'(cfg_slot_bytes);
   endfunction

   // expected result of one accepted request, state updated in place
   function automatic void ring_predict(input rcrsr_pkg::func_type op,
                                        input logic [SIZE_W-1:0] nbytes);
      ring_rsp_type r;
      r.status  = rcrsr_pkg::STATUS_OK;
      r.addr    = '0;
      r.content = '0;
      case (op)
         rcrsr_pkg::FUNC_RESERVE: begin
            if (nbytes > cfg_slot_bytes) begin
               r.status = rcrsr_pkg::STATUS_TOO_LARGE;
            end else if (next_index(rsv_idx) == rel_idx) begin
               r.status = rcrsr_pkg::STATUS_FULL;
            end else begin
               r.addr  = slot_addr(rsv_idx);
               rsv_idx = next_index(rsv_idx);
            end
         end
         rcrsr_pkg::FUNC_COMMIT: begin
            if (nbytes > cfg_slot_bytes) begin
               r.status = rcrsr_pkg::STATUS_TOO_LARGE;
            end else if (cmt_idx == rsv_idx) begin
               r.status = rcrsr_pkg::STATUS_NONE_RESERVED;
            end else begin
               size_table[cmt_idx] = nbytes;
               wr_bytes  = wr_bytes + TOTAL_W'(nbytes);
               wr_slots  = wr_slots + 1;
               r.content = nbytes;
               cmt_idx   = next_index(cmt_idx);
            end
         end
         rcrsr_pkg::FUNC_READ: begin
            if (rel_idx == cmt_idx) begin
               r.status = rcrsr_pkg::STATUS_EMPTY;
            end else begin
               r.content = size_table[rel_idx];
               rd_bytes  = rd_bytes + TOTAL_W'(r.content);
               rd_slots  = rd_slots + 1;
               r.addr    = slot_addr(rel_idx);
            end
         end
         default: begin
            if (rel_idx == cmt_idx) begin
               r.status = rcrsr_pkg::STATUS_EMPTY;
            end else begin
               rel_idx = next_index(rel_idx);
            end
         end
      endcase
      r.wr_bytes = wr_bytes;
      r.wr_slots = wr_slots;
      r.rd_bytes = rd_bytes;
      r.rd_slots = rd_slots;
      rsp_expected.push_back(r);
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         if (shown < 10) begin
            $display("mismatch %s: expected %h, got %h", name, want, got);
            shown++;
         end
      end
   endfunction

   function automatic void check_result(input logic [RSP_DATA_W-1:0] d);
      ring_rsp_type want;
      if (rsp_expected.size() == 0) begin
         fail_count++;
         if (shown < 10) begin
            $display("result with no request pending: %h", d);
            shown++;
         end
         return;
      end
      want = rsp_expected.pop_front();
      compare_field("status", 32'(want.status), 32'(d[RSP_STATUS_LO +: 3]));
      compare_field("slot_address", want.addr, d[RSP_ADDR_LO +: ADDR_W]);
      compare_field("content_bytes", 32'(want.content), 32'(d[RSP_CONTENT_LO +: SIZE_W]));
      compare_field("written_bytes_total", want.wr_bytes, d[WB_LO +: TOTAL_W]);
      compare_field("written_slots_total", want.wr_slots, d[WS_LO +: TOTAL_W]);
      compare_field("read_bytes_total", want.rd_bytes, d[RB_LO +: TOTAL_W]);
      compare_field("read_slots_total", want.rd_slots, d[RS_LO +: TOTAL_W]);
   endfunction

   // idle cycles before the next item, with runs of back-to-back traffic
   function automatic int pick_wait(inout bit calm);
      if ($urandom_range(0, 29) == 0) begin
         calm = !calm;
      end
      return calm ? 0 : int'($urandom_range(0, 13));
   endfunction

   function automatic void push_item(input rcrsr_pkg::func_type op,
                                     input logic [SIZE_W-1:0] nbytes);
      ring_req_type it;
      it.func   = op;
      it.nbytes = nbytes;
      req_backlog.push_back(it);
   endfunction

   // request driver
   always @(posedge clock) begin : drive_req
      ring_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_hold   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            ring_predict(rcrsr_pkg::func_type'(req_tuser), req_tdata);
         end
         if (req_tvalid && !req_tready) begin
            // hold the current item until its transfer
         end else if (req_hold > 0) begin
            req_tvalid <= 1'b0;
            req_hold   <= req_hold - 1;
         end else if (req_backlog.size() > 0) begin
            nxt = req_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= nxt.func;
            req_tdata  <= nxt.nbytes;
            req_hold   <= pick_wait(req_calm);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result monitor with random back-pressure
   always @(posedge clock) begin : watch_rsp
      int g;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         check_result(rsp_tdata);
         g = pick_wait(rsp_calm);
         rsp_hold   <= g;
         rsp_tready <= (g == 0);
      end else if (rsp_hold > 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= (rsp_hold == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("[reserve_commit_release_slot_ring] ERROR");
         $finish;
      end
   end

   // sample between edges so driver and monitor updates have settled
   task automatic wait_idle();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_tvalid || rsp_expected.size() != 0);
      @(posedge clock);
   endtask

   // release every committed slot, then write all three registers back to back
   task automatic reconfigure(input logic [SIZE_W-1:0] sb, input logic [8:0] cnt,
                              input logic [ADDR_W-1:0] base);
      logic [INDEX_W-1:0] t;
      int n;
      wait_idle();
      t = rel_idx;
      n = 0;
      while (t != cmt_idx) begin
         t = next_index(t);
         n++;
      end
      if (n > 0) begin
         for (int k = 0; k < n; k++) begin
            push_item(rcrsr_pkg::FUNC_RELEASE, SIZE_W'($urandom));
         end
         wait_idle();
      end
      csr_valid <= 1'b1;
      for (int k = 0; k < 3; k++) begin
         case (k)
            0: begin
               csr_index <= rcrsr_pkg::CSR_SLOT_BYTES;
               csr_data  <= {16'($urandom), sb};
            end
            1: begin
               csr_index <= rcrsr_pkg::CSR_SLOT_COUNT;
               csr_data  <= {23'($urandom), cnt};
            end
            default: begin
               csr_index <= rcrsr_pkg::CSR_DATA_BASE;
               csr_data  <= base;
            end
         endcase
         do @(posedge clock);
         while (!csr_ready);
         case (k)
            0: cfg_slot_bytes = sb;
            1: cfg_slot_count = COUNT_W'(cnt);
            default: cfg_data_base = base;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // random traffic biased toward reserve/commit/read/release in order
   task automatic queue_random(input int count, input int rsv_pct);
      int r;
      int pick;
      rcrsr_pkg::func_type op;
      logic [SIZE_W-1:0] nb;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if ($urandom_range(0, 19) == 0) begin
            op = rcrsr_pkg::func_type'($urandom_range(0, 3));
            nb = SIZE_W'($urandom);
         end else begin
            if (r < rsv_pct) begin
               op = rcrsr_pkg::FUNC_RESERVE;
            end else if (r < rsv_pct + (100 - rsv_pct) * 2 / 5) begin
               op = rcrsr_pkg::FUNC_COMMIT;
            end else if (r < rsv_pct + (100 - rsv_pct) * 3 / 5) begin
               op = rcrsr_pkg::FUNC_READ;
            end else begin
               op = rcrsr_pkg::FUNC_RELEASE;
            end
            if (op == rcrsr_pkg::FUNC_RESERVE || op == rcrsr_pkg::FUNC_COMMIT) begin
               pick = $urandom_range(0, 9);
               if (pick == 0) begin
                  nb = (cfg_slot_bytes == 16'hFFFF) ? 16'hFFFF :
                       SIZE_W'($urandom_range(int'(cfg_slot_bytes) + 1, 65535));
               end else if (pick == 1) begin
                  nb = cfg_slot_bytes;
               end else if (pick == 2) begin
                  nb = '0;
               end else begin
                  nb = SIZE_W'($urandom_range(0, int'(cfg_slot_bytes)));
               end
            end else begin
               nb = SIZE_W'($urandom);
            end
         end
         push_item(op, nb);
      end
   endtask

   initial begin : stimulus
      logic [SIZE_W-1:0] sb;
      logic [8:0]        cnt;
      logic [ADDR_W-1:0] base;
      for (int k = 0; k < MAX_SLOTS; k++) begin
         size_table[k] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty ring, nothing reserved, size limit at the reset slot size
      push_item(rcrsr_pkg::FUNC_READ, 16'd0);
      push_item(rcrsr_pkg::FUNC_RELEASE, 16'd0);
      push_item(rcrsr_pkg::FUNC_COMMIT, 16'd0);
      push_item(rcrsr_pkg::FUNC_RESERVE, 16'd65);
      push_item(rcrsr_pkg::FUNC_COMMIT, 16'hFFFF);
      push_item(rcrsr_pkg::FUNC_RESERVE, 16'd64);
      push_item(rcrsr_pkg::FUNC_RESERVE, 16'd0);
      push_item(rcrsr_pkg::FUNC_COMMIT, 16'd65);
      push_item(rcrsr_pkg::FUNC_COMMIT, 16'd64);
      push_item(rcrsr_pkg::FUNC_COMMIT, 16'd0);
      push_item(rcrsr_pkg::FUNC_COMMIT, 16'd1);
      // repeated reads count every time
      push_item(rcrsr_pkg::FUNC_READ, 16'd0);
      push_item(rcrsr_pkg::FUNC_READ, 16'hFFFF);
      push_item(rcrsr_pkg::FUNC_RELEASE, 16'd0);
      push_item(rcrsr_pkg::FUNC_READ, 16'd0);
      push_item(rcrsr_pkg::FUNC_RELEASE, 16'hFFFF);
      push_item(rcrsr_pkg::FUNC_RELEASE, 16'd0);
      push_item(rcrsr_pkg::FUNC_RESERVE, 16'hFFFF);
      push_item(rcrsr_pkg::FUNC_READ, 16'hFFFF);

      // two-slot ring: full after one reserve, size check ahead of full
      reconfigure(16'd64, 9'd2, 32'h0000_0100);
      push_item(rcrsr_pkg::FUNC_RESERVE, 16'd10);
      push_item(rcrsr_pkg::FUNC_RESERVE, 16'd10);
      push_item(rcrsr_pkg::FUNC_RESERVE, 16'd65);
      push_item(rcrsr_pkg::FUNC_COMMIT, 16'd10);
      push_item(rcrsr_pkg::FUNC_READ, 16'd0);
      push_item(rcrsr_pkg::FUNC_RELEASE, 16'd0);
      push_item(rcrsr_pkg::FUNC_RESERVE, 16'd64);

      // random phases across the register extremes
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin
               sb = 16'hFFFF; cnt = 9'h1FF; base = 32'hFFFF_FFFF;
            end
            1: begin
               sb = 16'd0; cnt = 9'd0; base = $urandom;
            end
            2: begin
               sb = 16'd1; cnt = 9'd1; base = 32'hFFFF_FFF0;
            end
            3: begin
               sb = SIZE_W'($urandom_range(2, 200)); cnt = 9'd3; base = $urandom;
            end
            4: begin
               sb = SIZE_W'($urandom); cnt = 9'd257; base = 32'h0;
            end
            5: begin
               sb = SIZE_W'($urandom_range(0, 63)); cnt = 9'($urandom_range(2, 12));
               base = $urandom;
            end
            6: begin
               sb = 16'hFFFF; cnt = 9'($urandom_range(0, 511)); base = $urandom;
            end
            default: begin
               sb = SIZE_W'($urandom_range(0, 4096)); cnt = 9'($urandom_range(2, 8));
               base = $urandom;
            end
         endcase
         reconfigure(sb, cnt, base);
         queue_random(25, 35);
      end

      // full-size ring driven until it fills
      reconfigure(SIZE_W'($urandom), 9'd256, $urandom);
      queue_random(30, 50);
      for (int k = 0; k < 258; k++) begin
         push_item(rcrsr_pkg::FUNC_RESERVE, 16'd0);
      end
      queue_random(20, 35);

      wait_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && rsp_expected.size() == 0) begin
         $display("[reserve_commit_release_slot_ring] OK");
      end else begin
         $display("[reserve_commit_release_slot_ring] ERROR");
      end
      $finish;
   end

endmodule
